// ----- hdl/dbscan_pkg.sv -----
// shared constants, codes and controller/datapath interface types for dbscan clustering
`default_nettype none
package dbscan_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CRD_W      = 12;
  localparam int RAD_W      = 12;
  localparam int MINN_W     = 6;
  localparam int CID_W      = 7;
  localparam int SQ_W       = 2 * CRD_W;
  localparam int R2_W       = 2 * RAD_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int MARK_W     = 2;
  localparam int MRAM_W     = MARK_W + CID_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(16);
  localparam logic [MINN_W-1:0] MINN_RST   = MINN_W'(4);

  // register index, taken from paddr[2]
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_MINN   = 1'b1;

  // per-point visit marks
  localparam logic [MARK_W-1:0] MK_FREE  = 2'd0;
  localparam logic [MARK_W-1:0] MK_VISIT = 2'd1;
  localparam logic [MARK_W-1:0] MK_NOISE = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLEAR,
    S_SEED_RD,
    S_SEED_CHK,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EXP_RD,
    S_EXP_Q,
    S_EXP_MK,
    S_EXP_CHK,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {ASEL_I, ASEL_C, ASEL_J} asel_t;

  typedef enum logic [1:0] {MW_CLEAR, MW_VISIT, MW_CORE, MW_NOISE} mw_t;

  typedef struct packed {
    logic  load_pt;
    logic  run_start;
    logic  clr_step;
    asel_t asel;
    logic  next_i;
    logic  scan_start;
    logic  c_from_i;
    logic  c_from_q;
    logic  scan_issue;
    logic  rollback;
    logic  mark_wr;
    mw_t   mw;
    logic  clust_inc;
    logic  idx_clr;
    logic  idx_inc;
    logic  emit_start;
    logic  emit_take;
    logic  flush;
    logic  run_done;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic clr_end;
    logic i_end;
    logic scan_last;
    logic pipe_busy;
    logic core;
    logic mark_zero;
    logic mark_noise;
    logic q_end;
    logic pend_v;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hdl/dbscan_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module dbscan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/dbscan_ctrl.sv -----
// clustering sequencer: load, clear, seed/expand scans and result output
`default_nettype none
module dbscan_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  dbscan_pkg::dp_sts_t sts,
  output dbscan_pkg::dp_cmd_t cmd,
  output logic                ld_rdy
);
  import dbscan_pkg::*;

  state_t state_r, state_nxt;
  logic   exp_r, exp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      exp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    unique case (state_r)
      S_LOAD: begin
        if (sts.in_valid && sts.in_last) state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        if (sts.clr_end) state_nxt = S_SEED_RD;
      end
      S_SEED_RD: begin
        state_nxt = sts.i_end ? S_EMIT_RD : S_SEED_CHK;
      end
      S_SEED_CHK: begin
        if (sts.mark_zero) begin
          state_nxt = S_SCAN;
          exp_nxt   = 1'b0;
        end else begin
          state_nxt = S_SEED_RD;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = (exp_r || sts.core) ? S_EXP_RD : S_SEED_RD;
      end
      S_EXP_RD: begin
        state_nxt = sts.q_end ? S_SEED_RD : S_EXP_Q;
      end
      S_EXP_Q: state_nxt = S_EXP_MK;
      S_EXP_MK: state_nxt = S_EXP_CHK;
      S_EXP_CHK: begin
        if (sts.mark_zero) begin
          state_nxt = S_SCAN;
          exp_nxt   = 1'b1;
        end else begin
          state_nxt = S_EXP_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = sts.i_end ? S_FLUSH : S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if (sts.mark_noise || !(sts.pend_v && !sts.out_free)) state_nxt = S_EMIT_RD;
      end
      S_FLUSH: begin
        if (!sts.pend_v || sts.out_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd    = '0;
    cmd.asel = ASEL_I;
    cmd.mw   = MW_CLEAR;
    ld_rdy = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        ld_rdy        = 1'b1;
        cmd.load_pt   = sts.in_valid;
        cmd.run_start = sts.in_valid && sts.in_last;
      end
      S_CLEAR: begin
        cmd.mark_wr  = 1'b1;
        cmd.mw       = MW_CLEAR;
        cmd.clr_step = 1'b1;
      end
      S_SEED_RD: begin
        cmd.emit_start = sts.i_end;
      end
      S_SEED_CHK: begin
        if (sts.mark_zero) begin
          cmd.scan_start = 1'b1;
          cmd.c_from_i   = 1'b1;
        end else begin
          cmd.next_i = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.asel       = ASEL_J;
        cmd.scan_issue = 1'b1;
      end
      S_DRAIN: begin
        cmd.asel = ASEL_J;
      end
      S_DECIDE: begin
        cmd.rollback = !sts.core;
        if (exp_r) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.mark_wr   = 1'b1;
          cmd.mw        = sts.core ? MW_CORE : MW_NOISE;
          cmd.clust_inc = sts.core;
          cmd.idx_clr   = sts.core;
          cmd.next_i    = !sts.core;
        end
      end
      S_EXP_RD: begin
        cmd.next_i = sts.q_end;
      end
      S_EXP_Q: begin
        cmd.c_from_q = 1'b1;
      end
      S_EXP_MK: begin
        cmd.asel = ASEL_C;
      end
      S_EXP_CHK: begin
        cmd.asel = ASEL_C;
        if (sts.mark_zero) begin
          cmd.mark_wr    = 1'b1;
          cmd.mw         = MW_VISIT;
          cmd.scan_start = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EMIT_RD: begin
        cmd.asel = ASEL_I;
      end
      S_EMIT_CHK: begin
        if (sts.mark_noise) begin
          cmd.next_i = 1'b1;
        end else if (!(sts.pend_v && !sts.out_free)) begin
          cmd.emit_take = 1'b1;
          cmd.next_i    = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.flush    = sts.pend_v && sts.out_free;
        cmd.run_done = !sts.pend_v || sts.out_free;
      end
      default: begin
        cmd.asel = ASEL_I;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/dbscan_dpath.sv -----
// point, mark and queue stores, distance pipeline, config registers and result register
`default_nettype none
module dbscan_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dbscan_pkg::dp_cmd_t                 cmd,
  output dbscan_pkg::dp_sts_t                 sts,
  input  logic                                in_valid,
  input  logic [dbscan_pkg::CRD_W-1:0]        in_x_coord,
  input  logic [dbscan_pkg::CRD_W-1:0]        in_y_coord,
  input  logic                                in_last_point,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dbscan_pkg::PADDR_W-1:0]      paddr,
  input  logic [dbscan_pkg::PDATA_W-1:0]      pwdata,
  output logic [dbscan_pkg::PDATA_W-1:0]      prdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dbscan_pkg::CRD_W-1:0]        out_x,
  output logic [dbscan_pkg::CRD_W-1:0]        out_y,
  output logic [dbscan_pkg::CID_W-1:0]        out_cluster_id,
  output logic                                out_last_result
);
  import dbscan_pkg::*;

  // configuration
  logic [RAD_W-1:0]  radius_r;
  logic [MINN_W-1:0] minn_r;
  logic [R2_W-1:0]   r2_r;

  // run control registers
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      i_r;
  logic [IDX_W-1:0]      clr_r;
  logic [IDX_W-1:0]      c_r;
  logic [IDX_W-1:0]      j_r;
  logic [CNT_W-1:0]      idx_r;
  logic [CNT_W-1:0]      qlen_r;
  logic [CNT_W-1:0]      qbase_r;
  logic [CNT_W-1:0]      n_r;
  logic [CID_W-1:0]      clust_r;
  logic [MAX_POINTS-1:0] flags_r;
  logic [MAX_POINTS-1:0] added_r;
  logic [CRD_W-1:0]      cx_r, cy_r;

  // distance pipeline
  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] j1_r, j2_r, j3_r;
  logic [CRD_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r;

  // pending and output results
  logic             pend_v_r;
  logic [CRD_W-1:0] pend_x_r, pend_y_r;
  logic [CID_W-1:0] pend_c_r;
  logic             out_valid_r, out_last_r;
  logic [CRD_W-1:0] out_x_r, out_y_r;
  logic [CID_W-1:0] out_c_r;

  // memories
  logic [2*CRD_W-1:0] pt_rd, pt_wd;
  logic [IDX_W-1:0]   pt_ra;
  logic               pt_we;
  logic [MRAM_W-1:0]  mk_rd, mk_wd;
  logic [IDX_W-1:0]   mk_ra, mk_wa;
  logic [IDX_W-1:0]   q_rd;
  logic               q_we;

  logic [CRD_W-1:0]  rx, ry, dx_c, dy_c;
  logic [SUM_W-1:0]  dist_sq;
  logic              hit, hit_new;
  logic [CNT_W-1:0]  nm1;
  logic              out_free;
  logic              cfg_wr;

  assign rx = pt_rd[2*CRD_W-1:CRD_W];
  assign ry = pt_rd[CRD_W-1:0];

  assign pt_we = cmd.load_pt && (count_r < CNT_W'(MAX_POINTS));
  assign pt_wd = {in_x_coord, in_y_coord};

  always_comb begin
    unique case (cmd.asel)
      ASEL_I:  pt_ra = i_r[IDX_W-1:0];
      ASEL_C:  pt_ra = c_r;
      ASEL_J:  pt_ra = j_r;
      default: pt_ra = i_r[IDX_W-1:0];
    endcase
  end

  assign mk_ra = (cmd.asel == ASEL_C) ? c_r : i_r[IDX_W-1:0];
  assign mk_wa = (cmd.mw == MW_CLEAR) ? clr_r : c_r;

  always_comb begin
    unique case (cmd.mw)
      MW_CLEAR: mk_wd = {MK_FREE, CID_W'(0)};
      MW_VISIT: mk_wd = {MK_VISIT, clust_r};
      MW_CORE:  mk_wd = {MK_VISIT, clust_r + CID_W'(1)};
      MW_NOISE: mk_wd = {MK_NOISE, CID_W'(0)};
      default:  mk_wd = {MK_FREE, CID_W'(0)};
    endcase
  end

  dbscan_ram #(.WIDTH(2*CRD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk  (clk),
    .we   (pt_we),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(pt_wd),
    .raddr(pt_ra),
    .rdata(pt_rd)
  );

  dbscan_ram #(.WIDTH(MRAM_W), .DEPTH(MAX_POINTS)) u_mk_ram (
    .clk  (clk),
    .we   (cmd.mark_wr),
    .waddr(mk_wa),
    .wdata(mk_wd),
    .raddr(mk_ra),
    .rdata(mk_rd)
  );

  dbscan_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_q_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(qlen_r[IDX_W-1:0]),
    .wdata(j3_r),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(q_rd)
  );

  // distance test: absolute differences of the read point, then the third-stage sum and radius compare
  assign dx_c    = (rx >= cx_r) ? (rx - cx_r) : (cx_r - rx);
  assign dy_c    = (ry >= cy_r) ? (ry - cy_r) : (cy_r - ry);
  assign dist_sq = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign hit     = v3_r && (dist_sq <= SUM_W'(r2_r));
  assign hit_new = hit && !flags_r[j3_r] && (j3_r != c_r);
  assign q_we    = hit_new;

  assign nm1      = (n_r == '0) ? '0 : (n_r - CNT_W'(1));
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      minn_r   <= MINN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RADIUS: radius_r <= pwdata[RAD_W-1:0];
        REG_MINN:   minn_r   <= pwdata[MINN_W-1:0];
        default:    radius_r <= radius_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIUS: prdata = PDATA_W'(radius_r);
      REG_MINN:   prdata = PDATA_W'(minn_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    j1_r  <= j_r;
    j2_r  <= j1_r;
    j3_r  <= j2_r;
    dx_r  <= dx_c;
    dy_r  <= dy_c;
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    if (cmd.scan_start) begin
      cx_r <= rx;
      cy_r <= ry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // run bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      i_r     <= '0;
      clr_r   <= '0;
      c_r     <= '0;
      j_r     <= '0;
      idx_r   <= '0;
      qlen_r  <= '0;
      qbase_r <= '0;
      n_r     <= '0;
      clust_r <= '0;
      flags_r <= '0;
      added_r <= '0;
    end else begin
      if (pt_we) count_r <= count_r + CNT_W'(1);
      if (cmd.run_done) count_r <= '0;

      if (cmd.run_start) begin
        i_r     <= '0;
        clr_r   <= '0;
        clust_r <= '0;
        flags_r <= '0;
        qlen_r  <= '0;
      end
      if (cmd.clr_step) clr_r <= clr_r + IDX_W'(1);
      if (cmd.clust_inc) clust_r <= clust_r + CID_W'(1);

      if (cmd.c_from_i) c_r <= i_r[IDX_W-1:0];
      if (cmd.c_from_q) c_r <= q_rd;

      if (cmd.idx_clr) idx_r <= '0;
      if (cmd.idx_inc) idx_r <= idx_r + CNT_W'(1);

      if (cmd.scan_start) begin
        j_r     <= '0;
        n_r     <= '0;
        added_r <= '0;
        qbase_r <= qlen_r;
      end
      if (cmd.scan_issue) j_r <= j_r + IDX_W'(1);

      if (hit) n_r <= n_r + CNT_W'(1);
      if (hit_new) begin
        flags_r[j3_r] <= 1'b1;
        added_r[j3_r] <= 1'b1;
        qlen_r        <= qlen_r + CNT_W'(1);
      end

      // non-core point: withdraw what its scan queued
      if (cmd.rollback) begin
        flags_r <= flags_r & ~added_r;
        qlen_r  <= qbase_r;
      end
      if (cmd.next_i) begin
        i_r     <= i_r + CNT_W'(1);
        flags_r <= '0;
        qlen_r  <= '0;
      end
      if (cmd.emit_start) i_r <= '0;
    end
  end

  // result hold with one-deep lookahead so the last transfer can be flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.emit_start) pend_v_r <= 1'b0;
      if (cmd.emit_take) begin
        pend_v_r <= 1'b1;
        if (pend_v_r) out_valid_r <= 1'b1;
      end
      if (cmd.flush) begin
        pend_v_r    <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_take) begin
      pend_x_r <= rx;
      pend_y_r <= ry;
      pend_c_r <= mk_rd[CID_W-1:0];
    end
    if ((cmd.emit_take && pend_v_r) || cmd.flush) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_c_r    <= pend_c_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_cluster_id  = out_c_r;
  assign out_last_result = out_last_r;

  always_comb begin
    sts            = '0;
    sts.in_valid   = in_valid;
    sts.in_last    = in_last_point;
    sts.clr_end    = (clr_r == IDX_W'(MAX_POINTS - 1));
    sts.i_end      = (i_r == count_r);
    sts.scan_last  = ((CNT_W'(j_r) + CNT_W'(1)) == count_r);
    sts.pipe_busy  = v1_r || v2_r || v3_r;
    sts.core       = (nm1 >= CNT_W'(minn_r));
    sts.mark_zero  = (mk_rd[MRAM_W-1:CID_W] == MK_FREE);
    sts.mark_noise = (mk_rd[MRAM_W-1:CID_W] == MK_NOISE);
    sts.q_end      = (idx_r == qlen_r);
    sts.pend_v     = pend_v_r;
    sts.out_free   = out_free;
  end

endmodule
`default_nettype wire

// ----- hdl/dbscan_point_clustering.sv -----
// top level of the dbscan point clustering block
// Points are taken one per cycle into a 64-entry store; the point with last_point set starts
// a run, during which in_stall stays high. A run first clears every entry of the visit/cluster
// store, then every point that gets visited costs one scan over all stored points through the
// single read port of the point store. Results then leave in load order, one store read per
// stored point, with noise points skipped and the final one marked by out_last_result; a run
// where every point is noise gives no transfer. radius and min_neighbours are written over the
// apb port; the user must write them between runs only, the block does not enforce it.
`default_nettype none
module dbscan_point_clustering (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dbscan_pkg::CRD_W-1:0]        in_x_coord,
  input  logic [dbscan_pkg::CRD_W-1:0]        in_y_coord,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dbscan_pkg::CRD_W-1:0]        out_x,
  output logic [dbscan_pkg::CRD_W-1:0]        out_y,
  output logic [dbscan_pkg::CID_W-1:0]        out_cluster_id,
  output logic                                out_last_result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dbscan_pkg::PADDR_W-1:0]      paddr,
  input  logic [dbscan_pkg::PDATA_W-1:0]      pwdata,
  output logic [dbscan_pkg::PDATA_W-1:0]      prdata,
  output logic                                pready
);
  import dbscan_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ld_rdy;

  assign in_stall = !ld_rdy;
  assign pready   = 1'b1;

  dbscan_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd),
    .ld_rdy(ld_rdy)
  );

  dbscan_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_valid),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_last_point  (in_last_point),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_cluster_id (out_cluster_id),
    .out_last_result(out_last_result)
  );

endmodule
`default_nettype wire

// ----- hdl/dbscan_chk.sv -----
// port-level checks for the dbscan clustering top level, bound in below
`default_nettype none
module dbscan_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [dbscan_pkg::CRD_W-1:0]        out_x,
  input logic [dbscan_pkg::CRD_W-1:0]        out_y,
  input logic [dbscan_pkg::CID_W-1:0]        out_cluster_id,
  input logic                                out_last_result
);
  import dbscan_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_cluster_id) && $stable(out_last_result))
    else $error("stalled result changed");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cluster_id != '0) && (out_cluster_id <= CID_W'(MAX_POINTS)))
    else $error("cluster number out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result && !out_stall |=> !out_valid)
    else $error("result after the last one of a run");

endmodule

bind dbscan_point_clustering dbscan_chk u_chk (.*);
`default_nettype wire

// ----- verif/dbscan_point_clustering_tb.sv -----
// self-checking testbench for the dbscan point clustering block
`default_nettype none
module dbscan_point_clustering_tb;
  import dbscan_pkg::*;

  typedef struct {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CID_W-1:0] cid;
    logic             last;
  } cpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CRD_W-1:0] in_x_coord = '0;
  logic [CRD_W-1:0] in_y_coord = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CRD_W-1:0] out_x;
  logic [CRD_W-1:0] out_y;
  logic [CID_W-1:0] out_cluster_id;
  logic out_last_result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dbscan_point_clustering u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_cluster_id(out_cluster_id),
    .out_last_result(out_last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [RAD_W-1:0]  radius_q = RADIUS_RST;
  logic [MINN_W-1:0] minn_q   = MINN_RST;
  logic [CRD_W-1:0]  px [MAX_POINTS];
  logic [CRD_W-1:0]  py [MAX_POINTS];
  logic [MARK_W-1:0] mark [MAX_POINTS];
  logic [CID_W-1:0]  clus [MAX_POINTS];
  bit                queued [MAX_POINTS];
  int                seeds [MAX_POINTS];
  int                qlen;
  int                npts = 0;
  cpoint_t           clustered_q [$];

  int  errors = 0;
  int  hold_len = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  rand_stall = 1'b1;
  bit  fast = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic bit near(input int a, input int b);
    longint dx, dy, r;
    dx = (px[a] > px[b]) ? px[a] - px[b] : px[b] - px[a];
    dy = (py[a] > py[b]) ? py[a] - py[b] : py[b] - py[a];
    r = radius_q;
    return dx <= r && dy <= r && dx * dx + dy * dy <= r * r;
  endfunction

  function automatic int scan_point(input int c);
    int n, added;
    n = 0;
    added = 0;
    for (int j = 0; j < npts; j++) begin
      if (near(j, c)) begin
        n++;
        if (!queued[j] && j != c && qlen < MAX_POINTS) begin
          queued[j] = 1'b1;
          seeds[qlen++] = j;
          added++;
        end
      end
    end
    n = (n > 0) ? n - 1 : 0;
    if (n < minn_q) begin
      for (int k = 1; k <= added; k++) queued[seeds[qlen - k]] = 1'b0;
      qlen -= added;
    end
    return n;
  endfunction

  task automatic cluster_points();
    int ccount, idx, p, dummy, lastpos;
    cpoint_t item;
    ccount = 0;
    qlen = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      mark[i] = MK_FREE;
      clus[i] = '0;
      queued[i] = 1'b0;
    end
    for (int i = 0; i < npts; i++) begin
      if (mark[i] == MK_FREE) begin
        mark[i] = MK_VISIT;
        if (scan_point(i) >= minn_q) begin
          ccount = (ccount + 1) & 7'h7f;
          clus[i] = CID_W'(ccount);
          idx = 0;
          while (idx < qlen) begin
            p = seeds[idx];
            if (mark[p] == MK_FREE) begin
              mark[p] = MK_VISIT;
              dummy = scan_point(p);
              if (clus[p] == 0) clus[p] = CID_W'(ccount);
            end
            idx++;
          end
        end else begin
          mark[i] = MK_NOISE;
        end
      end
      for (int q = 0; q < qlen; q++) queued[seeds[q]] = 1'b0;
      qlen = 0;
    end
    lastpos = -1;
    for (int i = 0; i < npts; i++) begin
      if (mark[i] != MK_NOISE) begin
        item.x = px[i];
        item.y = py[i];
        item.cid = clus[i];
        item.last = 1'b0;
        clustered_q = {clustered_q, item};
        lastpos = clustered_q.size() - 1;
      end
    end
    if (lastpos >= 0) clustered_q[lastpos].last = 1'b1;
    npts = 0;
  endtask

  // valid stays high after a transfer until the next falling edge drives the next item or idles
  task automatic send_point(input int x, input int y, input bit lastp);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= CRD_W'(x);
    in_y_coord <= CRD_W'(y);
    in_last_point <= lastp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (npts < MAX_POINTS) begin
      px[npts] = CRD_W'(x);
      py[npts] = CRD_W'(y);
      npts++;
    end
    if (lastp) cluster_points();
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (clustered_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    // a run that ends all noise gives no transfer, so wait for the block to take input again
    while (in_stall && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RADIUS) radius_q = RAD_W'(value);
    else minn_q = MINN_W'(value);
  endtask

  task automatic send_set(input int n, input int span, input int bx, input int by);
    for (int i = 0; i < n; i++)
      send_point(bx + $urandom_range(0, span), by + $urandom_range(0, span), i == n - 1);
  endtask

  // result checker
  always @(posedge clk) begin
    cpoint_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (clustered_q.size() == 0) begin
        report("unexpected transfer x", out_x, -1);
      end else begin
        e = clustered_q.pop_front();
        if (out_x !== e.x) report("out_x", out_x, e.x);
        if (out_y !== e.y) report("out_y", out_y, e.y);
        if (out_cluster_id !== e.cid) report("cluster_id", out_cluster_id, e.cid);
        if (out_last_result !== e.last) report("last_result", out_last_result, e.last);
      end
    end
  end

  // receiver stall, with long holds counted here
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rand_stall) begin
      out_stall <= ($urandom_range(0, 16) > 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_edges();
    send_point(0, 0, 1'b0);
    send_point(4095, 4095, 1'b0);
    send_point(4095, 0, 1'b0);
    send_point(0, 4095, 1'b0);
    send_point(12'haaa, 12'h555, 1'b0);
    send_point(12'h555, 12'haaa, 1'b1);
    wait_drained();
    // all noise
    send_set(5, 4095, 0, 0);
    wait_drained();
    // a dense cluster, then a far noise point loaded with a second cluster
    send_set(8, 6, 100, 100);
    send_point(3000, 3000, 1'b0);
    send_set(7, 6, 2000, 2000);
    wait_drained();
  endtask

  task automatic test_radius_extremes();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_MINN, 1);
    send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b0);
    send_point(8, 7, 1'b1);
    wait_drained();
    write_reg(REG_RADIUS, 4095);
    write_reg(REG_MINN, 63);
    send_set(10, 4095, 0, 0);
    wait_drained();
    write_reg(REG_MINN, 1);
    send_set(6, 4095, 0, 0);
    wait_drained();
  endtask

  task automatic test_store_full();
    write_reg(REG_RADIUS, 40);
    write_reg(REG_MINN, 3);
    for (int i = 0; i < 70; i++)
      send_point($urandom_range(0, 200), $urandom_range(0, 200), i == 69);
    wait_drained();
  endtask

  task automatic test_backpressure();
    // long receiver hold while the next set keeps coming
    write_reg(REG_RADIUS, 30);
    write_reg(REG_MINN, 2);
    send_set(20, 60, 500, 500);
    hold_len = 3000;
    hold_req++;
    fast = 1'b1;
    send_set(12, 60, 900, 900);
    fast = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    int sent, n;
    sent = 0;
    while (sent < 320) begin
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_RADIUS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                     : $urandom_range(5, 80));
        write_reg(REG_MINN, $urandom_range(1, 6));
      end
      rand_stall = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 14);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) == 0)
          send_point($urandom, $urandom, k == n - 1);
        else
          send_point(300 + $urandom_range(0, 150), 300 + $urandom_range(0, 150), k == n - 1);
      end
      sent += n;
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_radius_extremes();
    test_store_full();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0 && clustered_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
